FILE: hw/rtl/rlap_pkg.sv
// Package with the shared types and codes of the retry ladder attempt planner.
`default_nettype none

package rlap_pkg;

  localparam int unsigned MaxAttemptsDef = 8;
  localparam int unsigned CntW = 4;
  localparam int unsigned AddrW = 5;

  localparam logic [1:0] FuncClear  = 2'd0;
  localparam logic [1:0] FuncAsk    = 2'd1;
  localparam logic [1:0] FuncRecord = 2'd2;

  localparam logic [1:0] KindOffer = 2'd0;
  localparam logic [1:0] KindDone  = 2'd1;
  localparam logic [1:0] KindNeed  = 2'd2;
  localparam logic [1:0] KindAck   = 2'd3;

  localparam logic [1:0] TrustUnknown  = 2'd0;
  localparam logic [1:0] TrustMismatch = 2'd2;

  localparam logic [1:0] StratPass   = 2'd0;
  localparam logic [1:0] StratSplit  = 2'd1;
  localparam logic [1:0] StratSplit2 = 2'd2;

  localparam logic [2:0] ResAlert    = 3'd1;
  localparam logic [2:0] ResConnFail = 3'd2;

  localparam logic [1:0] ManualNone = 2'd0;
  localparam logic [1:0] ManualPass = 2'd1;

  localparam logic [2:0] SrcNone   = 3'd0;
  localparam logic [2:0] SrcManual = 3'd1;
  localparam logic [2:0] SrcCached = 3'd2;
  localparam logic [2:0] SrcLadder = 3'd3;
  localparam logic [2:0] SrcCool   = 3'd4;

  localparam logic [2:0] RegContext = 3'd0;
  localparam logic [2:0] RegManual  = 3'd1;
  localparam logic [2:0] RegCached  = 3'd2;
  localparam logic [2:0] RegPrefer  = 3'd3;
  localparam logic [2:0] RegTimeout = 3'd4;

  localparam logic [15:0] TimeoutReset = 16'd3000;

  typedef struct packed {
    logic       target;
    logic [1:0] strategy;
    logic [2:0] result;
  } hist_entry_t;

  typedef struct packed {
    logic [5:0] tried;
    logic       unreachable;
    logic [2:0] first_direct_res;
    logic [2:0] last_res;
  } scan_flags_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rlap_if.sv
// Handshake channel interfaces for the request and result transfers.
`default_nettype none

interface rlap_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [1:0] trust_state;
  logic       rec_target;
  logic [1:0] rec_strategy;
  logic [2:0] rec_result;

  modport source (output valid, func, trust_state, rec_target, rec_strategy, rec_result,
                  input ready);
  modport sink (input valid, func, trust_state, rec_target, rec_strategy, rec_result,
                output ready);
endinterface

interface rlap_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  answer_kind;
  logic        next_target;
  logic [1:0]  next_strategy;
  logic [15:0] attempt_tmo;
  logic [2:0]  plan_source;

  modport source (output valid, answer_kind, next_target, next_strategy, attempt_tmo,
                  plan_source, input ready);
  modport sink (input valid, answer_kind, next_target, next_strategy, attempt_tmo,
                plan_source, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/retry_ladder_attempt_planner_unit.sv
// Top level of the retry ladder attempt planner with its register port and sequencer.
//
// One request is taken at a time. A clear or a record transfer goes from
// acceptance through the finish state to the output register; an ask transfer
// first scans the recorded attempts, one entry per cycle through the single
// read port of the history memory, and then goes through the finish state. A
// request with the unused function code is taken and gives no result. The
// result waits in an output register, and the next request is accepted while
// it waits, but the following result is held until the first one is taken.
// The user must write configuration registers only while no request is in
// flight; the block itself does not enforce this.
`default_nettype none

module retry_ladder_attempt_planner_unit import rlap_pkg::*; #(
  parameter int unsigned MaxAttempts = MaxAttemptsDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  rlap_req_if.sink          req_i,
  rlap_rsp_if.source        rsp_o,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StFin  = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [3:0]      ctx_q;
  logic [1:0]      manual_q;
  logic [2:0]      cached_q;
  logic            prefer_q;
  logic [15:0]     tmo_q;
  logic [CntW-1:0] count_q, count_d;
  logic [1:0]      func_q;
  logic [1:0]      trust_q;

  logic            accept;
  logic            cfg_wr;
  logic [2:0]      reg_idx;
  logic            hist_wr;
  logic            scan_start;
  logic            scan_done;
  scan_flags_t     flags;
  hist_entry_t     wr_entry;
  logic            out_load;

  logic            host, cool, listed, dbad;
  logic            cached_ok, cached_tg;
  logic [1:0]      cached_st;
  logic            ct;
  logic [2:0]      cidx;
  logic [1:0]      bf, bs;
  logic            t00, t10;
  logic            dres_fail;
  logic [1:0]      kind;
  logic            tg;
  logic [1:0]      st;
  logic [2:0]      src;

  logic            rsp_vld_q;
  logic [1:0]      rsp_kind_q;
  logic            rsp_tg_q;
  logic [1:0]      rsp_st_q;
  logic [15:0]     rsp_tmo_q;
  logic [2:0]      rsp_src_q;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q    <= '0;
      manual_q <= '0;
      cached_q <= '0;
      prefer_q <= 1'b0;
      tmo_q    <= TimeoutReset;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegContext: ctx_q    <= pwdata[3:0];
        RegManual:  manual_q <= pwdata[1:0];
        RegCached:  cached_q <= pwdata[2:0];
        RegPrefer:  prefer_q <= pwdata[0];
        RegTimeout: tmo_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegContext: prdata = {28'd0, ctx_q};
      RegManual:  prdata = {30'd0, manual_q};
      RegCached:  prdata = {29'd0, cached_q};
      RegPrefer:  prdata = {31'd0, prefer_q};
      RegTimeout: prdata = {16'd0, tmo_q};
      default:    prdata = '0;
    endcase
  end

  assign req_i.ready = (state_q == StIdle);
  assign accept      = req_i.valid && req_i.ready;
  assign hist_wr     = accept && (req_i.func == FuncRecord) && (count_q < CntW'(MaxAttempts));
  assign scan_start  = accept && (req_i.func == FuncAsk);
  assign out_load    = (state_q == StFin) && (!rsp_vld_q || rsp_o.ready);

  assign wr_entry.target   = req_i.rec_target;
  assign wr_entry.strategy = req_i.rec_strategy;
  assign wr_entry.result   = req_i.rec_result;

  rlap_hist #(
    .MaxAttempts(MaxAttempts)
  ) u_hist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (hist_wr),
    .wr_idx_i (count_q),
    .wr_data_i(wr_entry),
    .start_i  (scan_start),
    .count_i  (count_q),
    .done_o   (scan_done),
    .flags_o  (flags)
  );

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          case (req_i.func)
            FuncClear: begin
              count_d = '0;
              state_d = StFin;
            end
            FuncRecord: begin
              if (hist_wr) begin
                count_d = count_q + 1'b1;
              end
              state_d = StFin;
            end
            FuncAsk: state_d = StScan;
            default: ;
          endcase
        end
      end
      StScan: begin
        if (scan_done) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= req_i.func;
      trust_q <= req_i.trust_state;
    end
  end

  assign host      = ctx_q[0];
  assign cool      = ctx_q[1];
  assign listed    = ctx_q[2];
  assign dbad      = ctx_q[3];
  assign cached_ok = (cached_q != 3'd0) && (cached_q != 3'd7);
  assign cached_tg = (cached_q >= 3'd4);
  assign cached_st = cached_tg ? 2'(cached_q - 3'd4) : 2'(cached_q - 3'd1);
  assign ct        = (trust_q == TrustMismatch) ? cached_tg : 1'b0;
  assign cidx      = (ct ? 3'd3 : 3'd0) + {1'b0, cached_st};
  assign bf        = prefer_q ? StratSplit2 : StratSplit;
  assign bs        = prefer_q ? StratSplit : StratSplit2;
  assign t00       = flags.tried[0];
  assign t10       = flags.tried[3];
  assign dres_fail = !dbad && ((flags.unreachable && !t00) ||
                               (t00 && (flags.first_direct_res == ResConnFail)));

  always_comb begin
    kind = KindDone;
    tg   = 1'b0;
    st   = StratPass;
    if (count_q >= CntW'(MaxAttempts)) begin
      kind = KindDone;
    end else if ((count_q != '0) && (flags.last_res <= ResAlert)) begin
      kind = KindDone;
    end else if (!host || (manual_q == ManualPass)) begin
      kind = (count_q == '0) ? KindOffer : KindDone;
    end else if (cool) begin
      if (count_q == '0) begin
        kind = KindOffer;
        st   = listed ? bf : StratPass;
      end
    end else if (manual_q != ManualNone) begin
      if (count_q != '0) begin
        kind = KindDone;
      end else if (trust_q == TrustUnknown) begin
        kind = KindNeed;
      end else begin
        kind = KindOffer;
        tg   = (trust_q == TrustMismatch);
        st   = manual_q - 2'd1;
      end
    end else if (cached_ok && cached_tg && (trust_q == TrustUnknown)) begin
      kind = KindNeed;
    end else if (cached_ok && !flags.tried[cidx]) begin
      kind = KindOffer;
      tg   = ct;
      st   = cached_st;
    end else if (listed && !flags.unreachable &&
                 (!flags.tried[{1'b0, bf}] || !flags.tried[{1'b0, bs}])) begin
      kind = KindOffer;
      st   = !flags.tried[{1'b0, bf}] ? bf : bs;
    end else if (!dbad && !flags.unreachable && !t00) begin
      kind = KindOffer;
    end else if (trust_q == TrustUnknown) begin
      kind = KindNeed;
    end else if (trust_q == TrustMismatch) begin
      if (!t10) begin
        kind = KindOffer;
        tg   = 1'b1;
      end else if (!flags.tried[3'd3 + {1'b0, bf}]) begin
        kind = KindOffer;
        tg   = 1'b1;
        st   = bf;
      end else if (!flags.tried[3'd3 + {1'b0, bs}]) begin
        kind = KindOffer;
        tg   = 1'b1;
        st   = bs;
      end
    end else if (dres_fail || flags.unreachable) begin
      kind = KindDone;
    end else if (!flags.tried[{1'b0, bf}]) begin
      kind = KindOffer;
      st   = bf;
    end else if (!flags.tried[{1'b0, bs}]) begin
      kind = KindOffer;
      st   = bs;
    end
  end

  always_comb begin
    if (!host) begin
      src = SrcNone;
    end else if (manual_q != ManualNone) begin
      src = SrcManual;
    end else if (cool) begin
      src = SrcCool;
    end else if (cached_ok && (count_q <= CntW'(1))) begin
      src = SrcCached;
    end else begin
      src = SrcLadder;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (out_load) begin
      rsp_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      rsp_src_q <= src;
      if ((func_q == FuncAsk) && (kind == KindOffer)) begin
        rsp_kind_q <= KindOffer;
        rsp_tg_q   <= tg;
        rsp_st_q   <= st;
        rsp_tmo_q  <= tmo_q;
      end else begin
        rsp_kind_q <= (func_q == FuncAsk) ? kind : KindAck;
        rsp_tg_q   <= 1'b0;
        rsp_st_q   <= StratPass;
        rsp_tmo_q  <= '0;
      end
    end
  end

  assign rsp_o.valid         = rsp_vld_q;
  assign rsp_o.answer_kind   = rsp_kind_q;
  assign rsp_o.next_target   = rsp_tg_q;
  assign rsp_o.next_strategy = rsp_st_q;
  assign rsp_o.attempt_tmo   = rsp_tmo_q;
  assign rsp_o.plan_source   = rsp_src_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rlap_hist.sv
// Attempt history memory with a sequential scanner that gathers the match flags.
`default_nettype none

module rlap_hist import rlap_pkg::*; #(
  parameter int unsigned MaxAttempts = MaxAttemptsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        wr_en_i,
  input  wire logic [CntW-1:0] wr_idx_i,
  input  wire hist_entry_t wr_data_i,
  input  wire logic        start_i,
  input  wire logic [CntW-1:0] count_i,
  output logic             done_o,
  output scan_flags_t      flags_o
);

  localparam int unsigned IdxW = (MaxAttempts > 1) ? $clog2(MaxAttempts) : 1;

  hist_entry_t     mem_q [MaxAttempts];
  hist_entry_t     rd_q;
  logic            busy_q, busy_d;
  logic            pv_q, pv_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] pidx_q, pidx_d;
  logic            rd_en;
  scan_flags_t     flags_q, flags_d;
  logic            hit_direct;

  assign rd_en  = busy_q && (idx_q < count_i);
  assign done_o = busy_q && !rd_en && !pv_q;
  assign flags_o = flags_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i[IdxW-1:0]] <= wr_data_i;
    end
    if (rd_en) begin
      rd_q <= mem_q[idx_q[IdxW-1:0]];
    end
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    pidx_d = pidx_q;
    pv_d   = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (busy_q) begin
      if (rd_en) begin
        pv_d   = 1'b1;
        pidx_d = idx_q;
        idx_d  = idx_q + 1'b1;
      end else if (!pv_q) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pv_q   <= 1'b0;
      idx_q  <= '0;
      pidx_q <= '0;
    end else begin
      busy_q <= busy_d;
      pv_q   <= pv_d;
      idx_q  <= idx_d;
      pidx_q <= pidx_d;
    end
  end

  assign hit_direct = !rd_q.target && (rd_q.strategy == StratPass);

  always_comb begin
    flags_d = flags_q;
    if (start_i) begin
      flags_d = '0;
    end else if (pv_q) begin
      for (int t = 0; t < 2; t++) begin
        for (int s = 0; s < 3; s++) begin
          if ((rd_q.target == 1'(t)) && (rd_q.strategy == 2'(s))) begin
            flags_d.tried[3'(t*3+s)] = 1'b1;
          end
        end
      end
      if (!rd_q.target && (rd_q.result == ResConnFail)) begin
        flags_d.unreachable = 1'b1;
      end
      if (hit_direct && !flags_q.tried[0]) begin
        flags_d.first_direct_res = rd_q.result;
      end
      if (pidx_q == CntW'(count_i - 1'b1)) begin
        flags_d.last_res = rd_q.result;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    flags_q <= flags_d;
  end

endmodule

`default_nettype wire
